// ----- sv/ik_pkg.sv -----
`default_nettype none
package ik_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int CORDIC_STAGES = 16;
  localparam int MAX_STAGES = 24;
  // Right shift from Q16 degrees to the output angle format.
  localparam int ASH = 16 - ANGLE_FRAC_BITS;
  // Datapath width of the vectoring CORDIC after normalization.
  localparam int CW = 51;

  localparam logic signed [31:0] DEG20  = 32'sd1310720;
  localparam logic signed [31:0] DEG90  = 32'sd5898240;
  localparam logic signed [31:0] DEG140 = 32'sd9175040;
  localparam logic signed [31:0] DEG165 = 32'sd10813440;
  localparam logic signed [31:0] DEG180 = 32'sd11796480;
  localparam logic signed [31:0] DEG360 = 32'sd23592960;

  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  localparam logic [21:0] ATAN_Q16 [MAX_STAGES] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117305,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  typedef enum logic [2:0] {
    REG_BASE_HEIGHT   = 3'd0,
    REG_UPPER_ARM_LEN = 3'd1,
    REG_FOREARM_LEN   = 3'd2,
    REG_GRIPPER_LEN   = 3'd3,
    REG_BASE_MID      = 3'd4,
    REG_SHOULDER_MID  = 3'd5,
    REG_ELBOW_MID     = 3'd6,
    REG_WRIST_MID     = 3'd7
  } ik_reg_e;

  // Everything a target picks up on its way down the pipeline.
  typedef struct packed {
    logic signed [14:0] x;
    logic signed [14:0] y;
    logic signed [14:0] z;
    logic signed [31:0] ga;
    logic               ok;
    logic signed [31:0] bas;
    logic [31:0]        rd;
    logic signed [31:0] go_y;
    logic signed [31:0] go_z;
    logic signed [25:0] wz;
    logic signed [25:0] wy;
    logic [50:0]        sq_wz;
    logic [50:0]        sq_wy;
    logic [41:0]        hh;
    logic [41:0]        uu;
    logic [51:0]        sw;
    logic [31:0]        ssw;
    logic signed [31:0] at;
    logic signed [55:0] num1;
    logic signed [55:0] den1;
    logic signed [55:0] num2;
    logic signed [55:0] den2;
    logic [5:0]         k1;
    logic [5:0]         k2;
    logic signed [31:0] n1;
    logic signed [31:0] d1;
    logic signed [31:0] n2;
    logic signed [31:0] d2;
    logic signed [31:0] ac1;
    logic signed [31:0] bpos;
    logic signed [31:0] spos;
    logic signed [31:0] epos;
    logic signed [31:0] wpos;
  } ik_ctx_t;

endpackage
`default_nettype wire

// ----- sv/four_joint_arm_inverse_kinematics.sv -----
// Inverse kinematics for a four-joint arm, one target word per cycle.
// The slave stream carries a target (x, y, z in 1/16 mm, grip angle in
// output angle units); the master stream returns one result word per target,
// in order: four servo positions in tdata and the reachable flag in tuser.
// An unreachable pose returns reachable low and all positions zero.
// Arm geometry and servo midpoints come from eight registers on the write
// port; change them only while no target is in flight.
// Throughput is one target per cycle unless the output stalls. Each target
// passes in turn through a chain of four bit-per-stage square root pipelines
// (32 stages each) and five CORDIC pipelines (one stage per iteration).
// The whole pipeline advances together: when the receiver holds tready low
// with a word waiting, every stage holds and s_axis_tready drops, so no word
// is lost or repeated. Reset empties the pipeline and loads the default arm
// geometry and midpoints.
`default_nettype none
module four_joint_arm_inverse_kinematics import ik_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // target_x [14:0], target_y [29:15], target_z [44:30], grip_angle [59:45]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // base_pos [13:0], shoulder_pos [27:14], elbow_pos [41:28], wrist_pos [55:42]
  output logic [55:0] m_axis_tdata,
  // reachable [0]
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [13:0] cfg_data_i
);

  logic [12:0] base_height_q, upper_q, fore_q, grip_q;
  logic [13:0] base_mid_q, shoulder_mid_q, elbow_mid_q, wrist_mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_height_q  <= 13'd1104;
      upper_q        <= 13'd2336;
      fore_q         <= 13'd2952;
      grip_q         <= 13'd1152;
      base_mid_q     <= 14'(90 << ANGLE_FRAC_BITS);
      shoulder_mid_q <= 14'(81 << ANGLE_FRAC_BITS);
      elbow_mid_q    <= 14'(88 << ANGLE_FRAC_BITS);
      wrist_mid_q    <= 14'(93 << ANGLE_FRAC_BITS);
    end else if (cfg_we_i) begin
      unique case (ik_reg_e'(cfg_idx_i))
        REG_BASE_HEIGHT:   base_height_q  <= cfg_data_i[12:0];
        REG_UPPER_ARM_LEN: upper_q        <= cfg_data_i[12:0];
        REG_FOREARM_LEN:   fore_q         <= cfg_data_i[12:0];
        REG_GRIPPER_LEN:   grip_q         <= cfg_data_i[12:0];
        REG_BASE_MID:      base_mid_q     <= cfg_data_i;
        REG_SHOULDER_MID:  shoulder_mid_q <= cfg_data_i;
        REG_ELBOW_MID:     elbow_mid_q    <= cfg_data_i;
        REG_WRIST_MID:     wrist_mid_q    <= cfg_data_i;
      endcase
    end
  end

  logic [20:0] hum, uln;
  assign hum = {upper_q, 8'd0};
  assign uln = {fore_q, 8'd0};

  logic en;
  logic out_valid_q;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Input register.
  logic    v_t0_q;
  ik_ctx_t ctx0_d, ctx_t0_q;

  always_comb begin
    ctx0_d    = '0;
    ctx0_d.x  = s_axis_tdata[14:0];
    ctx0_d.y  = s_axis_tdata[29:15];
    ctx0_d.z  = s_axis_tdata[44:30];
    ctx0_d.ga = 32'($signed(s_axis_tdata[59:45])) <<< ASH;
    ctx0_d.ok = 1'b1;
  end

  // Base angle.
  logic               u1_v;
  logic signed [31:0] u1_z;
  ik_ctx_t            u1_c, c1;

  ik_atan2 u_base_atan (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v_t0_q),
    .b_i(32'(ctx_t0_q.x)), .a_i(32'(ctx_t0_q.y)), .ctx_i(ctx_t0_q),
    .vld_o(u1_v), .z_o(u1_z), .ctx_o(u1_c)
  );

  always_comb begin
    c1     = u1_c;
    c1.bas = u1_z;
  end

  // Radial distance.
  logic               v_t1_q;
  ik_ctx_t            ctx_t1_q;
  logic [63:0]        rad1_d, rad1_q;
  logic signed [31:0] xsq, ysq;

  assign xsq    = 32'(c1.x) * 32'(c1.x);
  assign ysq    = 32'(c1.y) * 32'(c1.y);
  assign rad1_d = 64'($unsigned(xsq + ysq)) << 16;

  logic        u2_v;
  logic [31:0] u2_root;
  ik_ctx_t     u2_c, c2;

  ik_isqrt u_rad_sqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v_t1_q), .rad_i(rad1_q), .ctx_i(ctx_t1_q),
    .vld_o(u2_v), .root_o(u2_root), .ctx_o(u2_c)
  );

  always_comb begin
    c2    = u2_c;
    c2.rd = u2_root;
  end

  // Gripper offset along the grip angle.
  logic               u3_v;
  logic signed [31:0] u3_c_val, u3_s_val;
  ik_ctx_t            u3_c, c3;

  ik_rotate u_grip_rot (
    .clk_i, .rst_ni, .en_i(en), .vld_i(u2_v), .len_i({grip_q, 8'd0}),
    .ang_i(c2.ga), .ctx_i(c2),
    .vld_o(u3_v), .c_o(u3_c_val), .s_o(u3_s_val), .ctx_o(u3_c)
  );

  always_comb begin
    c3      = u3_c;
    c3.go_y = u3_c_val;
    c3.go_z = u3_s_val;
  end

  // Wrist point, its squares and the arm length squares.
  logic    v_t2_q, v_t3_q, v_t4_q;
  ik_ctx_t ctx_t2_d, ctx_t2_q, ctx_t3_d, ctx_t3_q, ctx_t4_d, ctx_t4_q;

  always_comb begin
    logic signed [51:0] pz, py;
    ctx_t2_d    = c3;
    ctx_t2_d.wz = 26'(32'(c3.z) * 32'sd256 - c3.go_z
                      - $signed({11'd0, base_height_q, 8'd0}));
    ctx_t2_d.wy = 26'($signed(c3.rd) - c3.go_y);
    ctx_t3_d       = ctx_t2_q;
    pz             = 52'(ctx_t2_q.wz) * 52'(ctx_t2_q.wz);
    py             = 52'(ctx_t2_q.wy) * 52'(ctx_t2_q.wy);
    ctx_t3_d.sq_wz = 51'(pz);
    ctx_t3_d.sq_wy = 51'(py);
    ctx_t3_d.hh    = 42'(hum) * 42'(hum);
    ctx_t3_d.uu    = 42'(uln) * 42'(uln);
    ctx_t4_d       = ctx_t3_q;
    ctx_t4_d.sw    = 52'(ctx_t3_q.sq_wz) + 52'(ctx_t3_q.sq_wy);
  end

  // Shoulder-to-wrist distance and its direction.
  logic        u4_v;
  logic [31:0] u4_root;
  ik_ctx_t     u4_c, c4;

  ik_isqrt u_sw_sqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v_t4_q), .rad_i(64'(ctx_t4_q.sw)),
    .ctx_i(ctx_t4_q), .vld_o(u4_v), .root_o(u4_root), .ctx_o(u4_c)
  );

  always_comb begin
    c4     = u4_c;
    c4.ssw = u4_root;
  end

  logic               u5_v;
  logic signed [31:0] u5_z;
  ik_ctx_t            u5_c, c5;

  ik_atan2 u_sw_atan (
    .clk_i, .rst_ni, .en_i(en), .vld_i(u4_v),
    .b_i(32'(c4.wz)), .a_i(32'(c4.wy)), .ctx_i(c4),
    .vld_o(u5_v), .z_o(u5_z), .ctx_o(u5_c)
  );

  always_comb begin
    c5    = u5_c;
    c5.at = u5_z;
  end

  // Law of cosines: numerators, denominators, range check, normalization.
  logic    v_t5_q, v_t6_q, v_t7_q;
  ik_ctx_t ctx_t5_d, ctx_t5_q, ctx_t6_d, ctx_t6_q, ctx_t7_d, ctx_t7_q;

  always_comb begin
    ctx_t5_d      = c5;
    ctx_t5_d.den1 = $signed((56'(hum) * 56'(c5.ssw)) << 1);
    ctx_t5_d.den2 = $signed((56'(hum) * 56'(uln)) << 1);
    ctx_t5_d.num1 = $signed(56'(c5.hh) - 56'(c5.uu) + 56'(c5.sw));
    ctx_t5_d.num2 = $signed(56'(c5.hh) + 56'(c5.uu) - 56'(c5.sw));
    if (c5.ssw == '0) begin
      ctx_t5_d.ok = 1'b0;
    end
  end

  always_comb begin
    logic [5:0] m1, m2;
    ctx_t6_d = ctx_t5_q;
    if (ctx_t5_q.den1 <= 0 || ctx_t5_q.num1 > ctx_t5_q.den1 ||
        ctx_t5_q.num1 < -ctx_t5_q.den1) begin
      ctx_t6_d.ok = 1'b0;
    end
    if (ctx_t5_q.den2 <= 0 || ctx_t5_q.num2 > ctx_t5_q.den2 ||
        ctx_t5_q.num2 < -ctx_t5_q.den2) begin
      ctx_t6_d.ok = 1'b0;
    end
    m1 = '0;
    m2 = '0;
    for (int i = 30; i < 55; i++) begin
      if (ctx_t5_q.den1[i]) begin
        m1 = 6'(i - 29);
      end
      if (ctx_t5_q.den2[i]) begin
        m2 = 6'(i - 29);
      end
    end
    ctx_t6_d.k1 = m1;
    ctx_t6_d.k2 = m2;
  end

  always_comb begin
    logic signed [55:0] n1s, d1s, n2s, d2s;
    ctx_t7_d = ctx_t6_q;
    n1s = ctx_t6_q.num1 >>> ctx_t6_q.k1;
    d1s = ctx_t6_q.den1 >>> ctx_t6_q.k1;
    n2s = ctx_t6_q.num2 >>> ctx_t6_q.k2;
    d2s = ctx_t6_q.den2 >>> ctx_t6_q.k2;
    if (n1s > d1s) begin
      n1s = d1s;
    end else if (n1s < -d1s) begin
      n1s = -d1s;
    end
    if (n2s > d2s) begin
      n2s = d2s;
    end else if (n2s < -d2s) begin
      n2s = -d2s;
    end
    ctx_t7_d.n1 = 32'(n1s);
    ctx_t7_d.d1 = 32'(d1s);
    ctx_t7_d.n2 = 32'(n2s);
    ctx_t7_d.d2 = 32'(d2s);
  end

  // Shoulder acos term.
  logic        v_t8_q;
  ik_ctx_t     ctx_t8_q;
  logic [63:0] prod1_d, prod1_q;

  assign prod1_d = 64'(32'(ctx_t7_q.d1 - ctx_t7_q.n1)) * 64'(32'(ctx_t7_q.d1 + ctx_t7_q.n1));

  logic        u6_v;
  logic [31:0] u6_root;
  ik_ctx_t     u6_c;

  ik_isqrt u_acos1_sqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v_t8_q), .rad_i(prod1_q), .ctx_i(ctx_t8_q),
    .vld_o(u6_v), .root_o(u6_root), .ctx_o(u6_c)
  );

  logic               u7_v;
  logic signed [31:0] u7_z;
  ik_ctx_t            u7_c, c7;

  ik_atan2 u_acos1_atan (
    .clk_i, .rst_ni, .en_i(en), .vld_i(u6_v),
    .b_i($signed(u6_root)), .a_i(u6_c.n1), .ctx_i(u6_c),
    .vld_o(u7_v), .z_o(u7_z), .ctx_o(u7_c)
  );

  always_comb begin
    c7     = u7_c;
    c7.ac1 = u7_z;
  end

  // Elbow acos term.
  logic        v_t9_q;
  ik_ctx_t     ctx_t9_q;
  logic [63:0] prod2_d, prod2_q;

  assign prod2_d = 64'(32'(c7.d2 - c7.n2)) * 64'(32'(c7.d2 + c7.n2));

  logic        u8_v;
  logic [31:0] u8_root;
  ik_ctx_t     u8_c;

  ik_isqrt u_acos2_sqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v_t9_q), .rad_i(prod2_q), .ctx_i(ctx_t9_q),
    .vld_o(u8_v), .root_o(u8_root), .ctx_o(u8_c)
  );

  logic               u9_v;
  logic signed [31:0] u9_z;
  ik_ctx_t            u9_c;

  ik_atan2 u_acos2_atan (
    .clk_i, .rst_ni, .en_i(en), .vld_i(u8_v),
    .b_i($signed(u8_root)), .a_i(u8_c.n2), .ctx_i(u8_c),
    .vld_o(u9_v), .z_o(u9_z), .ctx_o(u9_c)
  );

  // Joint angles and servo positions.
  logic    v_t10_q;
  ik_ctx_t ctx_t10_d, ctx_t10_q;

  always_comb begin
    logic signed [31:0] shl, elb, wri;
    shl = u9_c.at + u9_c.ac1;
    elb = u9_z;
    wri = u9_c.ga - (elb - DEG180) - shl;
    ctx_t10_d      = u9_c;
    ctx_t10_d.bpos = $signed(32'(base_mid_q) << ASH) + u9_c.bas;
    ctx_t10_d.spos = $signed(32'(shoulder_mid_q) << ASH) + shl - DEG90;
    ctx_t10_d.epos = $signed(32'(elbow_mid_q) << ASH) - (elb - DEG90);
    ctx_t10_d.wpos = $signed(32'(wrist_mid_q) << ASH) + wri;
  end

  function automatic logic [13:0] to_out(logic signed [31:0] pos);
    logic [31:0] t;
    t = $unsigned(pos) + (32'd1 << (ASH - 1));
    return t[ASH+13:ASH];
  endfunction

  logic        ok_final;
  logic [55:0] tdata_d;

  always_comb begin
    ok_final = ctx_t10_q.ok;
    if (ctx_t10_q.bpos < 0 || ctx_t10_q.bpos > DEG180 ||
        ctx_t10_q.spos < DEG20 || ctx_t10_q.spos > DEG140 ||
        ctx_t10_q.epos < DEG20 || ctx_t10_q.epos > DEG165 ||
        ctx_t10_q.wpos < 0 || ctx_t10_q.wpos > DEG180) begin
      ok_final = 1'b0;
    end
    tdata_d = '0;
    if (ok_final) begin
      tdata_d = {to_out(ctx_t10_q.wpos), to_out(ctx_t10_q.epos),
                 to_out(ctx_t10_q.spos), to_out(ctx_t10_q.bpos)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_t0_q      <= 1'b0;
      v_t1_q      <= 1'b0;
      v_t2_q      <= 1'b0;
      v_t3_q      <= 1'b0;
      v_t4_q      <= 1'b0;
      v_t5_q      <= 1'b0;
      v_t6_q      <= 1'b0;
      v_t7_q      <= 1'b0;
      v_t8_q      <= 1'b0;
      v_t9_q      <= 1'b0;
      v_t10_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_t0_q      <= s_axis_tvalid;
      v_t1_q      <= u1_v;
      v_t2_q      <= u3_v;
      v_t3_q      <= v_t2_q;
      v_t4_q      <= v_t3_q;
      v_t5_q      <= u5_v;
      v_t6_q      <= v_t5_q;
      v_t7_q      <= v_t6_q;
      v_t8_q      <= v_t7_q;
      v_t9_q      <= u7_v;
      v_t10_q     <= u9_v;
      out_valid_q <= v_t10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_t0_q     <= ctx0_d;
      ctx_t1_q     <= c1;
      rad1_q       <= rad1_d;
      ctx_t2_q     <= ctx_t2_d;
      ctx_t3_q     <= ctx_t3_d;
      ctx_t4_q     <= ctx_t4_d;
      ctx_t5_q     <= ctx_t5_d;
      ctx_t6_q     <= ctx_t6_d;
      ctx_t7_q     <= ctx_t7_d;
      ctx_t8_q     <= ctx_t7_q;
      prod1_q      <= prod1_d;
      ctx_t9_q     <= c7;
      prod2_q      <= prod2_d;
      ctx_t10_q    <= ctx_t10_d;
      m_axis_tdata <= tdata_d;
      m_axis_tuser <= ok_final;
    end
  end

  assign m_axis_tvalid = out_valid_q;

`ifndef SYNTHESIS
  a_in_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v_t0_q)
    else $error("accepted word did not enter the pipeline");

  a_out_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (m_axis_tvalid == $past(v_t10_q)))
    else $error("output valid does not follow the last stage");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("unreachable result carries nonzero positions");
`endif

endmodule
`default_nettype wire

// ----- sv/ik_isqrt.sv -----
`default_nettype none
module ik_isqrt import ik_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [63:0] rad_i,
  input  ik_ctx_t     ctx_i,
  output logic        vld_o,
  output logic [31:0] root_o,
  output ik_ctx_t     ctx_o
);

  localparam int N = 32;

  logic        vq    [N];
  logic [63:0] radq  [N];
  logic [33:0] remq  [N];
  logic [31:0] rootq [N];
  ik_ctx_t     cq    [N];

  // One root bit per stage, two radicand bits consumed per stage.
  for (genvar j = 0; j < N; j++) begin : g_stage
    logic        vin;
    logic [63:0] rin;
    logic [33:0] min;
    logic [31:0] qin;
    ik_ctx_t     cin;
    logic [35:0] cur;
    logic [35:0] trial;

    if (j == 0) begin : g_first
      assign vin = vld_i;
      assign rin = rad_i;
      assign min = '0;
      assign qin = '0;
      assign cin = ctx_i;
    end else begin : g_next
      assign vin = vq[j-1];
      assign rin = radq[j-1];
      assign min = remq[j-1];
      assign qin = rootq[j-1];
      assign cin = cq[j-1];
    end

    assign cur   = {min, rin[63:62]};
    assign trial = {2'b00, qin, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq[j] <= 1'b0;
      end else if (en_i) begin
        vq[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        radq[j] <= {rin[61:0], 2'b00};
        cq[j]   <= cin;
        if (cur >= trial) begin
          remq[j]  <= 34'(cur - trial);
          rootq[j] <= {qin[30:0], 1'b1};
        end else begin
          remq[j]  <= cur[33:0];
          rootq[j] <= {qin[30:0], 1'b0};
        end
      end
    end
  end

  assign vld_o  = vq[N-1];
  assign root_o = rootq[N-1];
  assign ctx_o  = cq[N-1];

endmodule
`default_nettype wire

// ----- sv/ik_atan2.sv -----
`default_nettype none
module ik_atan2 import ik_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] a_i,
  input  ik_ctx_t            ctx_i,
  output logic               vld_o,
  output logic signed [31:0] z_o,
  output ik_ctx_t            ctx_o
);

  localparam int S = CORDIC_STAGES;

  logic signed [32:0] a1_d, b1_d, a1_q, b1_q, a2_q, b2_q;
  logic signed [31:0] z1_d, z1_q, z2_q, z3_q;
  logic [32:0]        m1_d, m1_q;
  logic [5:0]         k2_d, k2_q;
  logic               zero1_q, zero2_q, zero3_q;
  logic               v1_q, v2_q, v3_q;
  ik_ctx_t            c1_q, c2_q, c3_q;
  logic signed [CW-1:0] a3_q, b3_q;

  // Fold into the right half plane.
  always_comb begin
    logic signed [32:0] ae;
    logic signed [32:0] be;
    ae   = 33'(a_i);
    be   = 33'(b_i);
    a1_d = ae;
    b1_d = be;
    z1_d = '0;
    if (ae < 0) begin
      if (be >= 0) begin
        a1_d = be;
        b1_d = -ae;
        z1_d = DEG90;
      end else begin
        a1_d = -be;
        b1_d = ae;
        z1_d = -DEG90;
      end
    end
    m1_d = (b1_d < 0) ? 33'(-b1_d) : 33'(b1_d);
    if ($unsigned(a1_d) > m1_d) begin
      m1_d = $unsigned(a1_d);
    end
  end

  // Shift that brings the larger magnitude into [2^46, 2^47).
  always_comb begin
    logic [5:0] msb;
    msb = '0;
    for (int i = 0; i < 33; i++) begin
      if (m1_q[i]) begin
        msb = 6'(i);
      end
    end
    k2_d = 6'(46) - msb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q    <= a1_d;
      b1_q    <= b1_d;
      z1_q    <= z1_d;
      m1_q    <= m1_d;
      zero1_q <= (a_i == 0) && (b_i == 0);
      c1_q    <= ctx_i;
      a2_q    <= a1_q;
      b2_q    <= b1_q;
      z2_q    <= z1_q;
      k2_q    <= k2_d;
      zero2_q <= zero1_q;
      c2_q    <= c1_q;
      a3_q    <= CW'(a2_q) <<< k2_q;
      b3_q    <= CW'(b2_q) <<< k2_q;
      z3_q    <= z2_q;
      zero3_q <= zero2_q;
      c3_q    <= c2_q;
    end
  end

  logic                 vq  [S];
  logic                 zrq [S];
  logic signed [CW-1:0] aq  [S];
  logic signed [CW-1:0] bq  [S];
  logic signed [31:0]   zq  [S];
  ik_ctx_t              cq  [S];

  for (genvar j = 0; j < S; j++) begin : g_stage
    logic                 vin, zin;
    logic signed [CW-1:0] ain, bin;
    logic signed [31:0]   tin, step;
    ik_ctx_t              cin;

    if (j == 0) begin : g_first
      assign vin = v3_q;
      assign zin = zero3_q;
      assign ain = a3_q;
      assign bin = b3_q;
      assign tin = z3_q;
      assign cin = c3_q;
    end else begin : g_next
      assign vin = vq[j-1];
      assign zin = zrq[j-1];
      assign ain = aq[j-1];
      assign bin = bq[j-1];
      assign tin = zq[j-1];
      assign cin = cq[j-1];
    end

    assign step = $signed({10'd0, ATAN_Q16[j]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq[j] <= 1'b0;
      end else if (en_i) begin
        vq[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zrq[j] <= zin;
        cq[j]  <= cin;
        if (bin >= 0) begin
          aq[j] <= ain + (bin >>> j);
          bq[j] <= bin - (ain >>> j);
          zq[j] <= tin + step;
        end else begin
          aq[j] <= ain - (bin >>> j);
          bq[j] <= bin + (ain >>> j);
          zq[j] <= tin - step;
        end
      end
    end
  end

  assign vld_o = vq[S-1];
  assign z_o   = zrq[S-1] ? '0 : zq[S-1];
  assign ctx_o = cq[S-1];

endmodule
`default_nettype wire

// ----- sv/ik_rotate.sv -----
`default_nettype none
module ik_rotate import ik_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [20:0]        len_i,
  input  logic signed [31:0] ang_i,
  input  ik_ctx_t            ctx_i,
  output logic               vld_o,
  output logic signed [31:0] c_o,
  output logic signed [31:0] s_o,
  output ik_ctx_t            ctx_o
);

  localparam int S = CORDIC_STAGES;

  logic signed [31:0] ang1_d, ang1_q, a1_q;
  logic               flip1_d, flip1_q, v1_q;
  logic [50:0]        prod;
  ik_ctx_t            c1_q;

  assign prod = 51'(len_i) * 51'(INV_GAIN_Q30);

  // Wrap into (-180, 180], then fold into [-90, 90]. The grip angle field
  // spans less than one and a half turns, so one step each way is enough.
  always_comb begin
    ang1_d  = ang_i;
    flip1_d = 1'b0;
    if (ang1_d > DEG180) begin
      ang1_d = ang1_d - DEG360;
    end else if (ang1_d <= -DEG180) begin
      ang1_d = ang1_d + DEG360;
    end
    if (ang1_d > DEG90) begin
      ang1_d  = ang1_d - DEG180;
      flip1_d = 1'b1;
    end else if (ang1_d < -DEG90) begin
      ang1_d  = ang1_d + DEG180;
      flip1_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang1_q  <= ang1_d;
      flip1_q <= flip1_d;
      a1_q    <= $signed(32'(prod >> 30));
      c1_q    <= ctx_i;
    end
  end

  logic               vq [S];
  logic               fq [S];
  logic signed [31:0] aq [S];
  logic signed [31:0] bq [S];
  logic signed [31:0] rq [S];
  ik_ctx_t            cq [S];

  for (genvar j = 0; j < S; j++) begin : g_stage
    logic               vin, fin;
    logic signed [31:0] ain, bin, rin, step;
    ik_ctx_t            cin;

    if (j == 0) begin : g_first
      assign vin = v1_q;
      assign fin = flip1_q;
      assign ain = a1_q;
      assign bin = '0;
      assign rin = ang1_q;
      assign cin = c1_q;
    end else begin : g_next
      assign vin = vq[j-1];
      assign fin = fq[j-1];
      assign ain = aq[j-1];
      assign bin = bq[j-1];
      assign rin = rq[j-1];
      assign cin = cq[j-1];
    end

    assign step = $signed({10'd0, ATAN_Q16[j]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq[j] <= 1'b0;
      end else if (en_i) begin
        vq[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fq[j] <= fin;
        cq[j] <= cin;
        if (rin >= 0) begin
          aq[j] <= ain - (bin >>> j);
          bq[j] <= bin + (ain >>> j);
          rq[j] <= rin - step;
        end else begin
          aq[j] <= ain + (bin >>> j);
          bq[j] <= bin - (ain >>> j);
          rq[j] <= rin + step;
        end
      end
    end
  end

  assign vld_o = vq[S-1];
  assign c_o   = fq[S-1] ? -aq[S-1] : aq[S-1];
  assign s_o   = fq[S-1] ? -bq[S-1] : bq[S-1];
  assign ctx_o = cq[S-1];

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import ik_pkg::*;

  localparam longint D90 = 64'sd5898240;
  localparam longint D180 = 64'sd11796480;
  localparam longint D360 = 64'sd23592960;
  localparam longint FIT_LO = 64'sd1 <<< 46;
  localparam longint FIT_HI = 64'sd1 <<< 47;
  localparam int LATENCY = 153 + 5 * CORDIC_STAGES;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic signed [14:0] x;
    logic signed [14:0] y;
    logic signed [14:0] z;
    logic signed [14:0] ga;
  } target_t;

  typedef struct {
    bit        ok;
    bit [13:0] bpos;
    bit [13:0] spos;
    bit [13:0] epos;
    bit [13:0] wpos;
  } joints_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [13:0] cfg_data_i = '0;

  // Arm geometry and midpoints as the block should hold them.
  bit [12:0] arm_base_h, arm_upper, arm_fore, arm_grip;
  bit [13:0] mid_base, mid_shoulder, mid_elbow, mid_wrist;

  target_t targets_pending[$];
  joints_t joints_expected[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int results_seen = 0;
  int reachable_seen = 0;
  int cycles = 0;

  four_joint_arm_inverse_kinematics dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint floor_sqrt(input bit [63:0] v_in);
    bit [63:0] v, r, b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // Vectoring CORDIC: angle of the point (a, b) in Q16 degrees.
  function automatic longint vec_angle(input longint b_in, input longint a_in);
    longint a, b, z, t, m, da, db;
    a = a_in;
    b = b_in;
    z = 0;
    if (a == 0 && b == 0) return 0;
    if (a < 0) begin
      t = a;
      if (b >= 0) begin
        a = b; b = -t; z = D90;
      end else begin
        a = -b; b = t; z = -D90;
      end
    end
    m = (b < 0) ? -b : b;
    if (a > m) m = a;
    while (m < FIT_LO) begin
      a = a * 2; b = b * 2; m = m * 2;
    end
    while (m >= FIT_HI) begin
      a = a >>> 1; b = b >>> 1; m = m >>> 1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < MAX_STAGES; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a = a + da; b = b - db; z = z + longint'(ATAN_Q16[i]);
      end else begin
        a = a - da; b = b + db; z = z - longint'(ATAN_Q16[i]);
      end
    end
    return z;
  endfunction

  function automatic void rot_vec(input longint len, input longint ang_in,
                                  output longint c, output longint s);
    longint a, b, da, db, ang;
    bit flip;
    ang = ang_in;
    flip = 1'b0;
    b = 0;
    while (ang > D180) ang = ang - D360;
    while (ang <= -D180) ang = ang + D360;
    if (ang > D90) begin
      ang = ang - D180; flip = 1'b1;
    end else if (ang < -D90) begin
      ang = ang + D180; flip = 1'b1;
    end
    a = (len * longint'(INV_GAIN_Q30)) >>> 30;
    for (int i = 0; i < CORDIC_STAGES && i < MAX_STAGES; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (ang >= 0) begin
        a = a - da; b = b + db; ang = ang - longint'(ATAN_Q16[i]);
      end else begin
        a = a + da; b = b - db; ang = ang + longint'(ATAN_Q16[i]);
      end
    end
    c = flip ? -a : a;
    s = flip ? -b : b;
  endfunction

  function automatic longint arc_cos(input longint num_in, input longint den_in,
                                     inout bit ok);
    longint num, den, prod;
    num = num_in;
    den = den_in;
    if (den <= 0 || num > den || num < -den) begin
      ok = 1'b0;
      return 0;
    end
    while (den >= (64'sd1 <<< 30)) begin
      den = den >>> 1;
      num = num >>> 1;
    end
    if (num > den) num = den;
    if (num < -den) num = -den;
    prod = (den - num) * (den + num);
    return vec_angle(floor_sqrt(prod), num);
  endfunction

  function automatic bit [13:0] servo_word(input longint pos);
    longint r;
    r = (pos + (64'sd1 <<< (ASH - 1))) >>> ASH;
    return r[13:0];
  endfunction

  function automatic joints_t solve_joints(input target_t t);
    longint x, y, z, ga, scale, bas, rd, go_y, go_z, wz, wy, sw, ssw, hum, uln;
    longint shl, elb, wri, bpos, spos, epos, wpos;
    bit ok;
    joints_t j;
    x = t.x; y = t.y; z = t.z;
    scale = 64'sd1 <<< (16 - ANGLE_FRAC_BITS);
    ga = longint'(t.ga) * scale;
    ok = 1'b1;
    bas = vec_angle(x, y);
    rd = floor_sqrt((x * x + y * y) << 16);
    rot_vec(longint'(arm_grip) << 8, ga, go_y, go_z);
    wz = z * 256 - go_z - (longint'(arm_base_h) << 8);
    wy = rd - go_y;
    sw = wz * wz + wy * wy;
    ssw = floor_sqrt(sw);
    hum = longint'(arm_upper) << 8;
    uln = longint'(arm_fore) << 8;
    if (ssw == 0) ok = 1'b0;
    shl = vec_angle(wz, wy);
    shl = shl + arc_cos(hum * hum - uln * uln + sw, 2 * hum * ssw, ok);
    elb = arc_cos(hum * hum + uln * uln - sw, 2 * hum * uln, ok);
    wri = ga - (elb - D180) - shl;
    bpos = longint'(mid_base) * scale + bas;
    spos = longint'(mid_shoulder) * scale + shl - D90;
    epos = longint'(mid_elbow) * scale - (elb - D90);
    wpos = longint'(mid_wrist) * scale + wri;
    if (bpos < 0 || bpos > D180 || spos < longint'(DEG20) || spos > longint'(DEG140) ||
        epos < longint'(DEG20) || epos > longint'(DEG165) || wpos < 0 || wpos > D180)
      ok = 1'b0;
    j = '{default: 0};
    if (ok) begin
      j.ok = 1'b1;
      j.bpos = servo_word(bpos);
      j.spos = servo_word(spos);
      j.epos = servo_word(epos);
      j.wpos = servo_word(wpos);
    end
    return j;
  endfunction

  // Driver: the word stays on the bus until the block takes it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (targets_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
          target_t t;
          t = targets_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'b0, t.ga, t.z, t.y, t.x};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: predicts on input acceptance, checks on output acceptance.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, joints_expected.size());
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      target_t t;
      t.x = s_axis_tdata[14:0];
      t.y = s_axis_tdata[29:15];
      t.z = s_axis_tdata[44:30];
      t.ga = s_axis_tdata[59:45];
      joints_expected.push_back(solve_joints(t));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      joints_t e;
      results_seen <= results_seen + 1;
      if (joints_expected.size() == 0) begin
        errors <= errors + 1;
        $display("%0t unexpected word: expected none, actual ok=%0d data=%h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        e = joints_expected.pop_front();
        if (e.ok) reachable_seen <= reachable_seen + 1;
        if (m_axis_tuser !== e.ok || m_axis_tdata[13:0] !== e.bpos ||
            m_axis_tdata[27:14] !== e.spos || m_axis_tdata[41:28] !== e.epos ||
            m_axis_tdata[55:42] !== e.wpos) begin
          errors <= errors + 1;
          $display("%0t mismatch: expected %0d %0d %0d %0d %0d, actual %0d %0d %0d %0d %0d",
                   $time, e.ok, e.bpos, e.spos, e.epos, e.wpos, m_axis_tuser,
                   m_axis_tdata[13:0], m_axis_tdata[27:14], m_axis_tdata[41:28],
                   m_axis_tdata[55:42]);
        end
      end
    end
  end

  task automatic add_target(input int x, input int y, input int z, input int ga);
    target_t t;
    t.x = 15'(x); t.y = 15'(y); t.z = 15'(z); t.ga = 15'(ga);
    targets_pending.push_back(t);
  endtask

  task automatic write_reg(input ik_reg_e idx, input int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 14'(value);
    case (idx)
      REG_BASE_HEIGHT:   arm_base_h = 13'(value);
      REG_UPPER_ARM_LEN: arm_upper = 13'(value);
      REG_FOREARM_LEN:   arm_fore = 13'(value);
      REG_GRIPPER_LEN:   arm_grip = 13'(value);
      REG_BASE_MID:      mid_base = 14'(value);
      REG_SHOULDER_MID:  mid_shoulder = 14'(value);
      REG_ELBOW_MID:     mid_elbow = 14'(value);
      REG_WRIST_MID:     mid_wrist = 14'(value);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_arm(input int bh, input int up, input int fa, input int gr,
                           input int mb, input int ms, input int me, input int mw);
    write_reg(REG_BASE_HEIGHT, bh);
    write_reg(REG_UPPER_ARM_LEN, up);
    write_reg(REG_FOREARM_LEN, fa);
    write_reg(REG_GRIPPER_LEN, gr);
    write_reg(REG_BASE_MID, mb);
    write_reg(REG_SHOULDER_MID, ms);
    write_reg(REG_ELBOW_MID, me);
    write_reg(REG_WRIST_MID, mw);
  endtask

  task automatic drain;
    while (targets_pending.size() > 0 || s_axis_tvalid || joints_expected.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // Most targets lie in the arm's working volume; the rest span the full field range in x, y and z.
  task automatic add_random_targets(input int n);
    bit [14:0] rx, ry, rz, rg;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 65) begin
        add_target(int'($urandom_range(6000)) - 3000, $urandom_range(7000, 600),
                   int'($urandom_range(6000)) - 1500, int'($urandom_range(11520)) - 5760);
      end else begin
        rx = 15'($urandom()); ry = 15'($urandom()); rz = 15'($urandom());
        rg = 15'($urandom_range(23040));
        add_target(int'($signed(rx)), int'($signed(ry)), int'($signed(rz)),
                   int'(rg) - 11520);
      end
    end
  endtask

  initial begin
    arm_base_h = 13'd1104; arm_upper = 13'd2336; arm_fore = 13'd2952; arm_grip = 13'd1152;
    mid_base = 14'(90 << ANGLE_FRAC_BITS);
    mid_shoulder = 14'(81 << ANGLE_FRAC_BITS);
    mid_elbow = 14'(88 << ANGLE_FRAC_BITS);
    mid_wrist = 14'(93 << ANGLE_FRAC_BITS);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        1: write_arm(8191, 8191, 8191, 8191, 11520, 11520, 11520, 11520);
        2: write_arm(0, 1, 1, 0, 0, 0, 0, 0);
        3: write_arm(1500, 0, 2952, 0, 5760, 5184, 5632, 5952);
        4: write_arm(1104, 2336, 2952, 1152, 16383, 16383, 16383, 16383);
        5, 6: write_arm($urandom_range(2500), $urandom_range(4000, 1200),
                        $urandom_range(4000, 1200), $urandom_range(2000),
                        $urandom_range(6500, 5000), $urandom_range(6000, 4500),
                        $urandom_range(6500, 5000), $urandom_range(6500, 5000));
        default: ;
      endcase
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 66; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 66; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      if (ph == 0) begin
        // Target on the base axis, field extremes, and grip angles at a half turn.
        add_target(0, 0, 2000, 0);
        add_target(0, 0, 0, 0);
        add_target(16383, 16383, 16383, 11520);
        add_target(-16384, -16384, -16384, -11520);
        add_target(-16384, 16383, 0, 0);
        add_target(16383, -16384, 0, 0);
        add_target(0, 4000, 1104, 0);
        add_target(0, 4000, 1104, 11520);
        add_target(0, 4000, 1104, -11520);
        add_target(0, 3000, 2000, -5760);
        add_target(0, 3000, 2000, 5760);
        add_target(1500, 3500, 800, -2000);
        add_target(-1500, 3500, 800, -2000);
        add_target(0, -3000, 1000, 0);
        add_target(0, 6430, 1104, 0);
        add_target(0, 7000, 1104, 0);
        add_target(0, 500, 3000, 5760);
        add_target(0, 1, 0, 1);
        add_target(-1, 0, 0, -1);
      end
      if (ph == 2) begin
        // With no gripper and no base height this target sits on the shoulder.
        add_target(0, 0, 0, 0);
        add_target(0, 0, 0, 5760);
        add_target(0, 1, 0, 0);
      end
      add_random_targets(ph == 0 ? 200 : 215);
      drain();
    end

    $display("Ran %0d targets over seven arm settings and four handshake patterns.",
             results_seen);
    $display("%0d results were reachable poses, %0d errors.", reachable_seen, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
